// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, included by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/tlsm_pkg.sv -----
package tlsm_pkg;

  // field widths
  localparam int MIN_W    = 10;
  localparam int FPM_W    = 8;
  localparam int STEP_W   = 24;
  localparam int PCT_W    = 7;
  localparam int ACT_W    = 2;
  localparam int ELAP_W   = 8;
  localparam int COUNT_W  = MIN_W + FPM_W;     // photo count
  localparam int PROD_W   = STEP_W + PCT_W;    // travel times percent
  localparam int DVSR_W   = 25;                // count times 100
  localparam int IVL_W    = 16;
  localparam int ACC_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = STEP_W;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STEP_W-1:0]  steps_t;
  typedef logic [ACT_W-1:0]   action_t;

  // action codes
  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_START = 2'd1;
  localparam action_t ACT_STOP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MINUTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FPM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2R      = 3'd4;

  // constants
  localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd100;
  localparam logic [DVSR_W-1:0] PCT_SCALE  = 25'd100;
  localparam logic [IVL_W-1:0]  MS_PER_MIN = 16'd60000;
  localparam steps_t            STEPS_MAX  = 24'hFFFFFF;

endpackage

// ----- hw/rtl/tlsm_channels.sv -----
// input channel: one beat per item
interface tlsm_item_if import tlsm_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [ELAP_W-1:0]   elapsed_ms;
  logic                motor_idle;

  modport source (output valid, action, elapsed_ms, motor_idle, input ready);
  modport sink   (input valid, action, elapsed_ms, motor_idle, output ready);
endinterface

// result channel: one beat per item
interface tlsm_result_if import tlsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                move_valid;
  logic                move_to_end;
  steps_t              move_steps;
  logic                move_direction;
  logic                shutter_fire;
  logic                is_running;
  count_t              photos_taken;
  logic                start_refused;

  modport source (output valid, move_valid, move_to_end, move_steps, move_direction,
                  shutter_fire, is_running, photos_taken, start_refused, input ready);
  modport sink   (input valid, move_valid, move_to_end, move_steps, move_direction,
                  shutter_fire, is_running, photos_taken, start_refused, output ready);
endinterface

// ----- hw/rtl/tlsm_mul_serial.sv -----
// shift-add multiplier, one multiplier bit per cycle
module tlsm_mul_serial import tlsm_pkg::*; #(
  parameter int A_W = MIN_W,
  parameter int B_W = FPM_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;
  logic [CNT_W-1:0] cnt;

  // one partial product per cycle, lsb of b first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      acc  <= '0;
      a_sh <= P_W'(a);
      b_sh <= b;
      cnt  <= CNT_W'(B_W);
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign product = acc;

endmodule

// ----- hw/rtl/tlsm_div_serial.sv -----
// restoring divider, one quotient bit per cycle, msb first
module tlsm_div_serial import tlsm_pkg::*; #(
  parameter int N_W = PROD_W,
  parameter int D_W = DVSR_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [N_W-1:0]   q_sh;
  logic [D_W-1:0]   dvsr;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     shifted;
  logic [D_W+1:0]   trial;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, q_sh[N_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      q_sh <= dividend;
      dvsr <= divisor;
      cnt  <= CNT_W'(N_W);
    end else if (busy) begin
      if (trial[D_W+1]) begin
        rem  <= shifted[D_W-1:0];
        q_sh <= {q_sh[N_W-2:0], 1'b0};
      end else begin
        rem  <= trial[D_W-1:0];
        q_sh <= {q_sh[N_W-2:0], 1'b1};
      end
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = q_sh;

endmodule

// ----- hw/rtl/timelapse_shoot_and_move_sequencer.sv -----
// channel   dir  handshake       payload
// item      in   valid / ready   action, elapsed_ms, motor_idle
// result    out  valid / ready   move_*, shutter_fire, is_running, photos_taken, start_refused
// cfg       in   cfg_we          cfg_index, cfg_data
//
// a tick, a stop or a refused start goes from the held item through S_EXEC
// to the output register. an accepted start first runs the serial multipliers
// (photo count, travel times percent) in S_MUL, then the serial step divider
// alongside the interval divider in S_DIV.
// one item in flight; the next item is taken while a result waits in the
// output register. synchronous reset clears all sequencing state.
`include "assert_macros.svh"

module timelapse_shoot_and_move_sequencer import tlsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tlsm_item_if.sink             item,
  tlsm_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;

  // configuration registers
  logic [MIN_W-1:0] moving_minutes;
  logic [FPM_W-1:0] frames_per_minute;
  steps_t           steps_full_travel;
  logic [PCT_W-1:0] distance_percent;
  logic             left_to_right;

  // sequencing state
  logic             running;
  logic             homed_phase;
  logic [ACC_W-1:0] time_acc;
  logic [IVL_W-1:0] interval_ms;
  steps_t           steps_each_photo;
  count_t           photos_remaining;
  count_t           photo_counter;

  // held item
  action_t           x_act;
  logic [ELAP_W-1:0] x_elapsed;
  logic              x_idle;
  logic              x_refused;

  // output register
  logic   res_valid;
  logic   r_mv;
  logic   r_mend;
  steps_t r_steps;
  logic   r_dir;
  logic   r_fire;
  logic   r_run;
  count_t r_taken;
  logic   r_refused;

  logic item_acc;
  logic start_ok;
  logic mul_start;
  logic div_start;
  logic cnt_busy;
  logic prod_busy;
  logic step_busy;
  logic ivl_busy;
  count_t            count;
  logic [PROD_W-1:0] prod;
  logic [DVSR_W-1:0] dvsr;
  logic [PROD_W-1:0] step_q;
  logic [IVL_W-1:0]  ivl_q;
  steps_t            step_sat;
  logic              exec_go;

  // exec results
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] acc_next;
  logic             due;
  logic             run_next;
  logic             homed_next;
  count_t           remaining_next;
  count_t           counter_next;
  logic             e_mv;
  logic             e_mend;
  steps_t           e_steps;
  logic             e_dir;
  logic             e_fire;

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign start_ok   = (item.action == ACT_START) && (moving_minutes != '0) &&
                      (frames_per_minute != '0);
  assign mul_start  = item_acc && start_ok;
  assign div_start  = (state == S_MUL) && !cnt_busy && !prod_busy;
  assign exec_go    = (state == S_EXEC) && (!res_valid || result.ready);

  // photo count and travel product
  tlsm_mul_serial #(.A_W(MIN_W), .B_W(FPM_W)) u_mul_count (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (moving_minutes),
    .b       (frames_per_minute),
    .busy    (cnt_busy),
    .product (count)
  );

  tlsm_mul_serial #(.A_W(STEP_W), .B_W(PCT_W)) u_mul_prod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (steps_full_travel),
    .b       (distance_percent),
    .busy    (prod_busy),
    .product (prod)
  );

  // floor(floor(p / c) / 100) equals floor(p / (100 c))
  assign dvsr = DVSR_W'(count) * PCT_SCALE;

  tlsm_div_serial #(.N_W(PROD_W), .D_W(DVSR_W)) u_div_steps (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dvsr),
    .busy     (step_busy),
    .quotient (step_q)
  );

  // minutes cancel out of minutes * 60000 / count for a nonzero count
  tlsm_div_serial #(.N_W(IVL_W), .D_W(FPM_W)) u_div_ivl (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (MS_PER_MIN),
    .divisor  (frames_per_minute),
    .busy     (ivl_busy),
    .quotient (ivl_q)
  );

  // saturate steps per photo
  assign step_sat = (step_q[PROD_W-1:STEP_W] != '0) ? STEPS_MAX : step_q[STEP_W-1:0];

  // time pass and move decision
  always_comb begin
    acc_sum  = time_acc + ACC_W'(x_elapsed);
    due      = (acc_sum >= ACC_W'(interval_ms));
    acc_next = due ? (acc_sum - ACC_W'(interval_ms)) : acc_sum;

    run_next       = (x_act == ACT_STOP) ? 1'b0 : running;
    homed_next     = homed_phase;
    remaining_next = photos_remaining;
    counter_next   = photo_counter;
    e_mv    = 1'b0;
    e_mend  = 1'b0;
    e_steps = '0;
    e_dir   = 1'b0;
    e_fire  = 1'b0;

    if (run_next && x_idle) begin
      if (!homed_phase) begin
        e_mv       = 1'b1;
        e_mend     = 1'b1;
        e_steps    = STEPS_MAX;
        e_dir      = !left_to_right;
        homed_next = 1'b1;
      end else if (due) begin
        e_fire         = 1'b1;
        counter_next   = photo_counter + COUNT_W'(1);
        e_mv           = 1'b1;
        e_steps        = steps_each_photo;
        e_dir          = left_to_right;
        remaining_next = photos_remaining - COUNT_W'(1);
        if (remaining_next == '0) begin
          run_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      moving_minutes    <= '0;
      frames_per_minute <= '0;
      steps_full_travel <= '0;
      distance_percent  <= PCT_RESET;
      left_to_right     <= 1'b0;
      running           <= 1'b0;
      homed_phase       <= 1'b0;
      time_acc          <= '0;
      interval_ms       <= '0;
      steps_each_photo  <= '0;
      photos_remaining  <= '0;
      photo_counter     <= '0;
      res_valid         <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MINUTES: moving_minutes    <= cfg_data[MIN_W-1:0];
          REG_FPM:     frames_per_minute <= cfg_data[FPM_W-1:0];
          REG_TRAVEL:  steps_full_travel <= cfg_data[STEP_W-1:0];
          REG_PERCENT: distance_percent  <= cfg_data[PCT_W-1:0];
          REG_L2R:     left_to_right     <= cfg_data[0];
          default: ;
        endcase
      end

      // result beat taken with no new result behind it
      if (result.valid && result.ready && !exec_go) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            x_act     <= item.action;
            x_elapsed <= item.elapsed_ms;
            x_idle    <= item.motor_idle;
            x_refused <= (item.action == ACT_START) && !start_ok;
            state     <= start_ok ? S_MUL : S_EXEC;
          end
        end
        S_MUL: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // commit the new run
          if (!step_busy && !ivl_busy) begin
            steps_each_photo <= step_sat;
            interval_ms      <= ivl_q;
            photos_remaining <= count;
            photo_counter    <= '0;
            homed_phase      <= 1'b0;
            running          <= 1'b1;
            state            <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            time_acc         <= acc_next;
            running          <= run_next;
            homed_phase      <= homed_next;
            photos_remaining <= remaining_next;
            photo_counter    <= counter_next;
            res_valid        <= 1'b1;
            r_mv             <= e_mv;
            r_mend           <= e_mend;
            r_steps          <= e_steps;
            r_dir            <= e_dir;
            r_fire           <= e_fire;
            r_run            <= run_next;
            r_taken          <= counter_next;
            r_refused        <= x_refused;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.move_valid     = r_mv;
  assign result.move_to_end    = r_mend;
  assign result.move_steps     = r_steps;
  assign result.move_direction = r_dir;
  assign result.shutter_fire   = r_fire;
  assign result.is_running     = r_run;
  assign result.photos_taken   = r_taken;
  assign result.start_refused  = r_refused;

  // checks
  `ASSERT_IMPL(a_run_has_photos, clk, rst, running, photos_remaining != '0)
  `ASSERT_IMPL(a_fire_is_step, clk, rst, exec_go && e_fire, e_mv && !e_mend)
  `ASSERT_IMPL(a_units_quiet, clk, rst, state == S_IDLE,
               !cnt_busy && !prod_busy && !step_busy && !ivl_busy)
  `ASSERT_NEXT(a_tick_to_exec, clk, rst, item_acc && !start_ok, state == S_EXEC)

endmodule

// ----- bench/timelapse_shoot_and_move_sequencer_test.sv -----
`timescale 1ns / 1ps

module timelapse_shoot_and_move_sequencer_test;
  import tlsm_pkg::*;

  // action code outside the named set, taken as a tick
  localparam action_t ACT_SPARE = 2'd3;
  // cycles with no beat on either channel before the run is given up
  localparam int IDLE_LIMIT = 2000;
  // quiet cycles before a register write and at the end of the run
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic   mv;
    logic   mend;
    steps_t steps;
    logic   dir;
    logic   fire;
    logic   run;
    count_t photos;
    logic   refused;
  } move_report_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    action_t               act;
    logic [ELAP_W-1:0]     elapsed;
    logic                  idle;
    bit                    typed;
    move_report_t          want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlsm_item_if   item_ch ();
  tlsm_result_if result_ch ();

  timelapse_shoot_and_move_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [MIN_W-1:0]  cfg_minutes = '0;
  logic [FPM_W-1:0]  cfg_fpm     = '0;
  steps_t            cfg_travel  = '0;
  logic [PCT_W-1:0]  cfg_pct     = PCT_RESET;
  logic              cfg_l2r     = 1'b0;

  // sequencer state copies
  logic              seq_running = 1'b0;
  logic              seq_homed   = 1'b0;
  logic [ACC_W-1:0]  acc_ms      = '0;
  logic [IVL_W-1:0]  ivl_ms      = '0;
  steps_t            photo_steps = '0;
  count_t            photos_left = '0;
  count_t            photos_done = '0;

  move_report_t pending_reports[$];
  plan_row_t    plan[$];

  int errors     = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_shots    = 0;
  int n_homes    = 0;
  int n_refused  = 0;
  int n_settings = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit cfg_open   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected result of one item, state copies advanced
  task automatic advance_sequencer(input action_t act, input logic [ELAP_W-1:0] elapsed,
                                   input logic idle, output move_report_t rep);
    longint unsigned count;
    longint unsigned prod;
    longint unsigned steps;
    longint unsigned ivl;
    logic            due;
    rep = '0;
    due = 1'b0;
    if (act == ACT_START) begin
      count = 64'(cfg_minutes) * 64'(cfg_fpm);
      if (count == 0) begin
        rep.refused = 1'b1;
      end else begin
        prod = 64'(cfg_travel) * 64'(cfg_pct);
        steps = prod / count / 64'(PCT_SCALE);
        photo_steps = (steps > 64'(STEPS_MAX)) ? STEPS_MAX : steps[STEP_W-1:0];
        ivl = 64'(cfg_minutes) * 64'(MS_PER_MIN) / count;
        ivl_ms = ivl[IVL_W-1:0];
        photos_left = count[COUNT_W-1:0];
        photos_done = '0;
        seq_homed = 1'b0;
        seq_running = 1'b1;
      end
    end else if (act == ACT_STOP) begin
      seq_running = 1'b0;
    end
    // free-running time base
    acc_ms = acc_ms + ACC_W'(elapsed);
    if (acc_ms >= ACC_W'(ivl_ms)) begin
      acc_ms = acc_ms - ACC_W'(ivl_ms);
      due = 1'b1;
    end
    // homing first, then one shot per interval
    if (seq_running && idle) begin
      if (!seq_homed) begin
        rep.mv = 1'b1;
        rep.mend = 1'b1;
        rep.steps = STEPS_MAX;
        rep.dir = ~cfg_l2r;
        seq_homed = 1'b1;
      end else if (due) begin
        rep.fire = 1'b1;
        photos_done = photos_done + 1'b1;
        rep.mv = 1'b1;
        rep.steps = photo_steps;
        rep.dir = cfg_l2r;
        photos_left = photos_left - 1'b1;
        if (photos_left == 0) seq_running = 1'b0;
      end
    end
    rep.run = seq_running;
    rep.photos = photos_done;
  endtask

  function automatic move_report_t quiet_report(logic run, count_t photos, logic refused);
    move_report_t rep;
    rep = '0;
    rep.run = run;
    rep.photos = photos;
    rep.refused = refused;
    return rep;
  endfunction

  function automatic move_report_t homing_report(logic dir);
    move_report_t rep;
    rep = '0;
    rep.mv = 1'b1;
    rep.mend = 1'b1;
    rep.steps = STEPS_MAX;
    rep.dir = dir;
    rep.run = 1'b1;
    return rep;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // one item beat, with burst and gap shaping on the sender side
  task automatic send_item(input action_t act, input logic [ELAP_W-1:0] elapsed,
                           input logic idle, input bit typed, input move_report_t want);
    int           gap;
    move_report_t rep;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.elapsed_ms <= elapsed;
    item_ch.motor_idle <= idle;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    n_items++;
    advance_sequencer(act, elapsed, idle, rep);
    pending_reports.push_back(typed ? want : rep);
  endtask

  // hold the sender until every expected beat is in
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MINUTES: cfg_minutes = data[MIN_W-1:0];
      REG_FPM:     cfg_fpm = data[FPM_W-1:0];
      REG_TRAVEL:  cfg_travel = data[STEP_W-1:0];
      REG_PERCENT: cfg_pct = data[PCT_W-1:0];
      REG_L2R:     cfg_l2r = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int m, input int f, input int travel, input int pct,
                            input int l2r);
    drain_results();
    write_reg(REG_MINUTES, CFG_DATA_W'(m));
    write_reg(REG_FPM, CFG_DATA_W'(f));
    write_reg(REG_TRAVEL, CFG_DATA_W'(travel));
    write_reg(REG_PERCENT, CFG_DATA_W'(pct));
    write_reg(REG_L2R, CFG_DATA_W'(l2r));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic add_item(input action_t act, input int elapsed, input logic idle);
    plan_row_t row;
    row = '{default: '0};
    row.act = act;
    row.elapsed = ELAP_W'(elapsed);
    row.idle = idle;
    plan.push_back(row);
  endtask

  task automatic add_typed(input action_t act, input int elapsed, input logic idle,
                           input move_report_t want);
    plan_row_t row;
    row = '{default: '0};
    row.act = act;
    row.elapsed = ELAP_W'(elapsed);
    row.idle = idle;
    row.typed = 1'b1;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = CFG_DATA_W'(data);
    plan.push_back(row);
  endtask

  // result side: check each beat, then pick the next stall
  always @(posedge clk) begin
    move_report_t got;
    move_report_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.move_valid, result_ch.move_to_end, result_ch.move_steps,
                result_ch.move_direction, result_ch.shutter_fire, result_ch.is_running,
                result_ch.photos_taken, result_ch.start_refused};
        n_results++;
        if (got.fire) n_shots++;
        if (got.mend) n_homes++;
        if (got.refused) n_refused++;
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %0h",
                   $time, got);
        end else begin
          want = pending_reports.pop_front();
          check_field("move_valid", want.mv, got.mv);
          check_field("move_to_end", want.mend, got.mend);
          check_field("move_steps", want.steps, got.steps);
          check_field("move_direction", want.dir, got.dir);
          check_field("shutter_fire", want.fire, got.fire);
          check_field("is_running", want.run, got.run);
          check_field("photos_taken", want.photos, got.photos);
          check_field("start_refused", want.refused, got.refused);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(8, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(0, 1));
        default: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int m;
    int f;
    int travel;
    int pct;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.action = ACT_TICK;
    item_ch.elapsed_ms = '0;
    item_ch.motor_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: reset values, refused start, idle stop, spare code
    add_typed(ACT_TICK, 0, 1'b0, quiet_report(1'b0, '0, 1'b0));
    add_typed(ACT_TICK, 255, 1'b1, quiet_report(1'b0, '0, 1'b0));
    add_typed(ACT_START, 0, 1'b1, quiet_report(1'b0, '0, 1'b1));
    add_typed(ACT_STOP, 0, 1'b1, quiet_report(1'b0, '0, 1'b0));
    add_typed(ACT_SPARE, 170, 1'b0, quiet_report(1'b0, '0, 1'b0));
    // largest photo count, percent above full travel
    add_cfg(REG_MINUTES, 1023);
    add_cfg(REG_FPM, 255);
    add_cfg(REG_TRAVEL, 24'hFFFFFF);
    add_cfg(REG_PERCENT, 127);
    add_cfg(REG_L2R, 0);
    add_item(ACT_START, 85, 1'b0);
    add_typed(ACT_TICK, 0, 1'b1, homing_report(1'b1));
    add_item(ACT_TICK, 255, 1'b1);
    add_item(ACT_TICK, 255, 1'b0);
    add_item(ACT_TICK, 255, 1'b1);
    // restart while running goes back to homing
    add_item(ACT_START, 255, 1'b1);
    add_typed(ACT_STOP, 255, 1'b1, quiet_report(1'b0, '0, 1'b0));
    add_typed(ACT_STOP, 0, 1'b0, quiet_report(1'b0, '0, 1'b0));
    // other direction, zero travel
    add_cfg(REG_L2R, 1);
    add_cfg(REG_TRAVEL, 0);
    add_cfg(REG_PERCENT, 0);
    add_cfg(REG_MINUTES, 1);
    add_cfg(REG_FPM, 255);
    add_typed(ACT_START, 255, 1'b1, homing_report(1'b0));
    add_item(ACT_TICK, 255, 1'b1);
    add_item(ACT_TICK, 128, 1'b1);
    add_item(ACT_TICK, 255, 1'b1);
    add_item(ACT_SPARE, 255, 1'b1);
    // zero count refused while a run is active
    add_cfg(REG_FPM, 0);
    add_item(ACT_START, 0, 1'b1);
    add_item(ACT_TICK, 255, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_open) begin
          drain_results();
          cfg_open = 1'b1;
          n_settings++;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(plan[i].act, plan[i].elapsed, plan[i].idle, plan[i].typed, plan[i].want);
      end
    end

    // single-photo run with saturated step count
    set_config(1, 1, 24'hFFFFFF, $urandom_range(101, 127), 1);
    send_item(ACT_START, ELAP_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    repeat (205) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(ACT_SPARE, ELAP_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, '0);
      end else begin
        send_item(ACT_TICK, ELAP_W'($urandom_range(200, 255)), ($urandom_range(0, 9) != 0),
                  1'b0, '0);
      end
    end

    // random settings with starts, stops and restarts mixed in
    repeat (5) begin
      r = $urandom_range(0, 5);
      m = (r == 0) ? 1023 : (r == 1) ? 1 : $urandom_range(1, 40);
      r = $urandom_range(0, 5);
      f = (r == 0) ? 255 : (r == 1) ? 0 : (r == 2) ? 1 : $urandom_range(1, 255);
      r = $urandom_range(0, 3);
      travel = (r == 0) ? 0 : (r == 1) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
      r = $urandom_range(0, 4);
      pct = (r == 0) ? 0 : (r == 1) ? 127 : (r == 2) ? 100 : $urandom_range(0, 127);
      set_config(m, f, travel, pct, $urandom_range(0, 1));
      send_item(ACT_START, ELAP_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'b0, '0);
      repeat (44) begin
        r = $urandom_range(0, 99);
        send_item((r < 78) ? ACT_TICK : (r < 86) ? ACT_START : (r < 93) ? ACT_STOP : ACT_SPARE,
                  ELAP_W'($urandom_range(0, 255)), ($urandom_range(0, 3) != 0), 1'b0, '0);
      end
    end

    // wait out the last results
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d result beats from %0d item beats over %0d register settings",
             n_results, n_items, n_settings);
    $display("seen %0d shutter shots, %0d homing moves, %0d refused starts",
             n_shots, n_homes, n_refused);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- timelapse_shoot_and_move_sequencer.f -----
+incdir+hw/rtl
hw/rtl/tlsm_pkg.sv
hw/rtl/tlsm_channels.sv
hw/rtl/tlsm_mul_serial.sv
hw/rtl/tlsm_div_serial.sv
hw/rtl/timelapse_shoot_and_move_sequencer.sv
bench/timelapse_shoot_and_move_sequencer_test.sv
